// File: src/rrms_pkg.sv
package rrms_pkg;

    localparam int POINT_DEPTH_DEF = 1024;
    localparam int Y_BITS_DEF      = 16;
    localparam int VALUE_BITS_DEF  = 32;

    // fixed field widths of the channels
    localparam int ACTION_W = 2;
    localparam int RANK_W   = 10;
    localparam int PY_W     = 16;
    localparam int NEWV_W   = 32;
    localparam int BEST_W   = 32;

    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic take_item;
        logic clr_write;
        logic rmw_read;
        logic rmw_write;
        logic scan_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic                item_valid;
        logic [ACTION_W-1:0] action;
        logic                rank_ok;
        logic                query_empty;
        logic                clr_last;
        logic                scan_last;
        logic                out_free;
    } sts_t;

endpackage

// File: src/rrms_if.sv
interface rrms_item_if;
    logic                             valid;
    logic                             ready;
    logic [rrms_pkg::ACTION_W-1:0]    action;
    logic [rrms_pkg::RANK_W-1:0]      point_rank;
    logic [rrms_pkg::PY_W-1:0]        point_y;
    logic [rrms_pkg::NEWV_W-1:0]      new_value;
    logic [rrms_pkg::RANK_W-1:0]      rank_low;
    logic [rrms_pkg::RANK_W-1:0]      rank_high;
    logic [rrms_pkg::PY_W-1:0]        y_low;
    logic [rrms_pkg::PY_W-1:0]        y_high;

    modport source (output valid, action, point_rank, point_y, new_value, rank_low,
                    rank_high, y_low, y_high, input ready);
    modport sink (input valid, action, point_rank, point_y, new_value, rank_low,
                  rank_high, y_low, y_high, output ready);
endinterface

interface rrms_result_if;
    logic                          valid;
    logic                          ready;
    logic [rrms_pkg::BEST_W-1:0]   best_value;
    logic                          found;

    modport source (output valid, best_value, found, input ready);
    modport sink (input valid, best_value, found, output ready);
endinterface

// File: src/rrms_ctrl.sv
module rrms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  rrms_pkg::sts_t   sts,
    output rrms_pkg::cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_WR    = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.take_item = 1'b1;
                if (sts.item_valid)
                begin
                    case (sts.action)
                        rrms_pkg::ACT_LOAD, rrms_pkg::ACT_UPDATE:
                        begin
                            if (sts.rank_ok)
                            begin
                                state_next = S_RD;
                            end
                        end
                        rrms_pkg::ACT_QUERY:
                        begin
                            state_next = sts.query_empty ? S_OUT : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cmd.rmw_read = 1'b1;
                state_next   = S_WR;
            end
            S_WR:
            begin
                cmd.rmw_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: src/rrms_datapath.sv
module rrms_datapath #(
    parameter int POINT_DEPTH = rrms_pkg::POINT_DEPTH_DEF,
    parameter int Y_BITS      = rrms_pkg::Y_BITS_DEF,
    parameter int VALUE_BITS  = rrms_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    rrms_item_if.sink        items,
    rrms_result_if.source    results,
    input  rrms_pkg::cmd_t   cmd,
    output rrms_pkg::sts_t   sts
);

    localparam int ADDR_W = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
    localparam int YC_W   = (Y_BITS > rrms_pkg::PY_W) ? Y_BITS : rrms_pkg::PY_W;
    localparam int VC_W   = (VALUE_BITS > rrms_pkg::NEWV_W) ? VALUE_BITS : rrms_pkg::NEWV_W;
    localparam int MW     = 2 + Y_BITS + VALUE_BITS;

    // word: loaded, set, y, value
    logic [MW-1:0] mem [POINT_DEPTH];
    logic [MW-1:0] rd_reg;

    logic [rrms_pkg::ACTION_W-1:0] act_reg;
    logic [ADDR_W-1:0]             rank_reg;
    logic [Y_BITS-1:0]             py_reg;
    logic [VALUE_BITS-1:0]         val_reg;
    logic [ADDR_W-1:0]             rhi_reg;
    logic [YC_W-1:0]               ylo_reg;
    logic [YC_W-1:0]               yhi_reg;
    logic [ADDR_W-1:0]             scan_addr_reg;
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic                          cmp_valid_reg;
    logic [VALUE_BITS-1:0]         best_reg;
    logic                          hit_reg;
    logic                          out_valid_reg;
    logic [rrms_pkg::BEST_W-1:0]   out_best_reg;
    logic                          out_found_reg;

    logic                 accept;
    logic [YC_W-1:0]      py_wide;
    logic [YC_W-1:0]      y_top;
    logic [YC_W-1:0]      py_sat;
    logic [VC_W-1:0]      val_wide;
    logic [VC_W-1:0]      val_top;
    logic [VC_W-1:0]      val_sat;
    logic [31:0]          rhi_clamp;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [MW-1:0]        mem_wdata;
    logic                 rd_loaded;
    logic                 rd_set;
    logic [Y_BITS-1:0]    rd_y;
    logic [VALUE_BITS-1:0] rd_val;
    logic [YC_W-1:0]      rd_y_wide;
    logic                 in_rect;

    assign accept = items.valid && cmd.take_item;
    assign items.ready = cmd.take_item;

    // saturate incoming point y and value to the stored widths
    assign py_wide  = YC_W'(items.point_y);
    assign y_top    = YC_W'({Y_BITS{1'b1}});
    assign py_sat   = (py_wide > y_top) ? y_top : py_wide;
    assign val_wide = VC_W'(items.new_value);
    assign val_top  = VC_W'({VALUE_BITS{1'b1}});
    assign val_sat  = (val_wide > val_top) ? val_top : val_wide;

    assign rhi_clamp = (32'(items.rank_high) > 32'(POINT_DEPTH - 1)) ?
                       32'(POINT_DEPTH - 1) : 32'(items.rank_high);

    assign sts.item_valid  = items.valid;
    assign sts.action      = items.action;
    assign sts.rank_ok     = 32'(items.point_rank) < 32'(POINT_DEPTH);
    assign sts.query_empty = (32'(items.rank_low) > rhi_clamp) || (items.y_low > items.y_high);
    assign sts.clr_last    = clr_addr_reg == ADDR_W'(POINT_DEPTH - 1);
    assign sts.scan_last   = scan_addr_reg == rhi_reg;
    assign sts.out_free    = !out_valid_reg || results.ready;

    assign rd_loaded = rd_reg[MW-1];
    assign rd_set    = rd_reg[MW-2];
    assign rd_y      = rd_reg[VALUE_BITS +: Y_BITS];
    assign rd_val    = rd_reg[VALUE_BITS-1:0];
    assign rd_y_wide = YC_W'(rd_y);

    always_comb
    begin
        if (cmd.clr_write)
        begin
            mem_addr = clr_addr_reg;
        end
        else if (cmd.rmw_read || cmd.rmw_write)
        begin
            mem_addr = rank_reg;
        end
        else
        begin
            mem_addr = scan_addr_reg;
        end
    end

    // update of an unloaded rank leaves the entry alone
    assign mem_we = cmd.clr_write ||
                    (cmd.rmw_write && ((act_reg == rrms_pkg::ACT_LOAD) || rd_loaded));

    always_comb
    begin
        if (cmd.clr_write)
        begin
            mem_wdata = '0;
        end
        else if (act_reg == rrms_pkg::ACT_LOAD)
        begin
            mem_wdata = {1'b1, rd_set, py_reg, rd_val};
        end
        else
        begin
            mem_wdata = {1'b1, 1'b1, py_reg, val_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= items.action;
            rank_reg <= ADDR_W'(items.point_rank);
            py_reg   <= py_sat[Y_BITS-1:0];
            val_reg  <= val_sat[VALUE_BITS-1:0];
            rhi_reg  <= rhi_clamp[ADDR_W-1:0];
            ylo_reg  <= YC_W'(items.y_low);
            yhi_reg  <= YC_W'(items.y_high);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept)
            begin
                scan_addr_reg <= ADDR_W'(items.rank_low);
            end
            else if (cmd.scan_read)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            cmp_valid_reg <= cmd.scan_read;
        end
    end

    assign in_rect = rd_set && (rd_y_wide >= ylo_reg) && (rd_y_wide <= yhi_reg);

    // running maximum over the scanned ranks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            best_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else if (cmp_valid_reg && in_rect)
        begin
            if (!hit_reg || (rd_val > best_reg))
            begin
                best_reg <= rd_val;
            end
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_best_reg  <= rrms_pkg::BEST_W'(best_reg);
            out_found_reg <= hit_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.best_value = out_best_reg;
    assign results.found      = out_found_reg;

endmodule

// File: src/rect_range_max_store.sv
// rectangle max store: points keyed by x rank with a y coordinate and a value
// items channel (valid/ready): one beat is a load, update or rectangle query
//   load writes a point's y, update sets value and y of a loaded point,
//   query asks for the largest set value in the rank and y rectangle
// results channel (valid/ready): one beat per query with best_value and found
// sequencing
//   load and update each do a read-modify-write on the point memory
//   a query scans its rank range one entry a cycle through the single memory
//   port; an empty rectangle skips the scan and goes straight to the result
//   one item is in flight at a time; the next is taken once it is done
// reset
//   after rst_n releases, a clearing pass walks every entry of the point
//   memory; no items are taken during it
// stall
//   a finished result sits in an output register; the block returns to
//   taking items while it waits, and a further query holds at its end
//   until the receiver takes the pending beat
module rect_range_max_store #(
    parameter int POINT_DEPTH = rrms_pkg::POINT_DEPTH_DEF,
    parameter int Y_BITS      = rrms_pkg::Y_BITS_DEF,
    parameter int VALUE_BITS  = rrms_pkg::VALUE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    rrms_item_if.sink      items,
    rrms_result_if.source  results
);

    rrms_pkg::cmd_t cmd;
    rrms_pkg::sts_t sts;

    // sequencer for clear pass, read-modify-write and range scan
    rrms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // point memory, bound capture, running max and output register
    rrms_datapath #(
        .POINT_DEPTH (POINT_DEPTH),
        .Y_BITS      (Y_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cmd     (cmd),
        .sts     (sts)
    );

    // a beat without a hit always carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.found |-> results.best_value == '0)
        else $error("result without hit has nonzero value");

    // the memory port never serves a write and a scan read together
    assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.clr_write || cmd.rmw_write) && cmd.scan_read))
        else $error("memory write during scan");

    // a new result is loaded only when the pending one is gone or leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!results.valid || results.ready))
        else $error("pending result overwritten");

    // items are not taken while the memory is being cleared or worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !(cmd.clr_write || cmd.rmw_read || cmd.rmw_write || cmd.scan_read))
        else $error("item taken while busy");

endmodule
